FILE: hdl/rag_pkg.sv
// Shared sizes and cell interface types for the allocation-graph deadlock detector.
package rag_pkg;

   localparam int NUM_PROCS   = 32;
   localparam int NUM_RES     = 32;
   localparam int ID_W        = 5;
   localparam int CNT_W       = 16;
   localparam int PROCS_OUT_W = 32;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Broadcast control from the sequencer to every process cell.
   typedef struct packed {
      logic            clear;
      logic            start;
      logic            step;
      logic            wr_req;
      logic            wr_asg;
      logic [ID_W-1:0] res_id;
   } cell_ctl_type;

   // Data handed from one cell to the next along the row.
   typedef struct packed {
      logic [NUM_RES-1:0] res_any;
      logic               changed;
   } cell_chain_type;

endpackage

FILE: hdl/rag_deadlock_detector.sv
// Top level: edge intake, sink-peeling sequencer over a row of process cells, result register.
//
// Usage: each req_ beat carries one edge of a resource-allocation graph (req_type 0 is
// a request proc -> res, 1 an assignment res -> proc); req_first_edge starts a new list
// and clears the graph, the edge count and the deadlock latch before the edge is applied.
// Every accepted beat yields exactly one rsp_ beat with the edge index, the deadlock flag,
// the edge that first deadlocked and the mask of deadlocked processes.
// Sequence: when no deadlock is latched the edge is stored at the accepting edge, then
// the peel runs one round per cycle over all cells and resources at once until a round
// drops nothing, then the DONE state loads the result register once it is free.
// An edge that arrives while a deadlock is latched skips the peel and goes to the load.
// One edge at a time: the next edge is accepted only after the previous one has run
// through the peel rounds in the cell row and its result has been loaded.
// req_ready is high whenever the sequencer is idle, even while the previous result still
// waits in the rsp_ register; a stalled receiver holds the result there and the next
// edge's result waits in the sequencer until the register frees.
// Reset (synchronous, active high) clears the graph, the count, the latch and the result
// valid; no clearing pass is needed.
module rag_deadlock_detector (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [rag_pkg::ID_W-1:0]          req_proc_id,
   input  logic [rag_pkg::ID_W-1:0]          req_res_id,
   input  logic                              req_first_edge,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rag_pkg::CNT_W-1:0]         rsp_edge_number,
   output logic                              rsp_deadlock,
   output logic [rag_pkg::CNT_W-1:0]         rsp_deadlock_edge,
   output logic [rag_pkg::PROCS_OUT_W-1:0]   rsp_deadlocked_procs
);

   typedef enum logic [1:0] {IDLE, PEEL, DONE} state_type;

   state_type                          state_ff;
   logic [rag_pkg::CNT_W-1:0]          edge_counter_ff;
   logic [rag_pkg::CNT_W-1:0]          this_edge_ff;
   logic                               latched_ff;
   logic [rag_pkg::CNT_W-1:0]          latched_edge_ff;
   logic [rag_pkg::PROCS_OUT_W-1:0]    latched_procs_ff;
   logic [rag_pkg::NUM_RES-1:0]        res_alive_ff;
   logic                               rsp_valid_ff;
   logic [rag_pkg::CNT_W-1:0]          rsp_edge_number_ff;
   logic                               rsp_deadlock_ff;
   logic [rag_pkg::CNT_W-1:0]          rsp_deadlock_edge_ff;
   logic [rag_pkg::PROCS_OUT_W-1:0]    rsp_deadlocked_procs_ff;

   logic                               accept;
   logic                               latched_eff;
   logic                               in_range;
   logic [rag_pkg::CNT_W-1:0]          this_edge_in;
   logic [rag_pkg::CNT_W-1:0]          edge_counter_in;
   logic [rag_pkg::NUM_RES-1:0]        res_next;
   logic                               round_changed;
   logic                               slot_free;
   logic                               rsp_load;
   rag_pkg::cell_ctl_type              ctl;
   rag_pkg::cell_chain_type            chain [rag_pkg::NUM_PROCS+1];
   logic [rag_pkg::NUM_PROCS-1:0]      proc_alive;
   logic [rag_pkg::NUM_PROCS-1:0]      proc_sel;

   assign req_ready   = (state_ff == IDLE);
   assign accept      = req_valid & req_ready;
   assign latched_eff = latched_ff & ~req_first_edge;
   assign in_range    = (int'(req_proc_id) < rag_pkg::NUM_PROCS) &&
                        (int'(req_res_id) < rag_pkg::NUM_RES);

   assign this_edge_in    = req_first_edge ? '0 : edge_counter_ff;
   assign edge_counter_in = (this_edge_in == rag_pkg::CNT_MAX) ? this_edge_in
                                                                : this_edge_in + 1'b1;

   always_comb begin
      ctl.clear  = accept & req_first_edge;
      ctl.start  = accept & ~latched_eff;
      ctl.step   = (state_ff == PEEL);
      ctl.wr_req = accept & ~latched_eff & in_range & ~req_type;
      ctl.wr_asg = accept & ~latched_eff & in_range & req_type;
      ctl.res_id = req_res_id;
   end

   assign chain[0] = '0;

   for (genvar i = 0; i < rag_pkg::NUM_PROCS; i++) begin : g_cell
      assign proc_sel[i] = (req_proc_id == rag_pkg::ID_W'(i));
      rag_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .sel       (proc_sel[i]),
         .res_alive (res_alive_ff),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1]),
         .alive     (proc_alive[i])
      );
   end

   // A resource stays only while some live process still holds it.
   assign res_next      = res_alive_ff & chain[rag_pkg::NUM_PROCS].res_any;
   assign round_changed = chain[rag_pkg::NUM_PROCS].changed | (res_next != res_alive_ff);
   assign slot_free     = ~rsp_valid_ff | rsp_ready;
   assign rsp_load      = (state_ff == DONE) & slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= IDLE;
         edge_counter_ff <= '0;
         latched_ff      <= 1'b0;
         latched_edge_ff <= '0;
         latched_procs_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (accept) begin
                  this_edge_ff    <= this_edge_in;
                  edge_counter_ff <= edge_counter_in;
                  if (req_first_edge) begin
                     latched_ff       <= 1'b0;
                     latched_edge_ff  <= '0;
                     latched_procs_ff <= '0;
                  end
                  res_alive_ff <= '1;
                  state_ff     <= latched_eff ? DONE : PEEL;
               end
            end
            PEEL: begin
               res_alive_ff <= res_next;
               if (!round_changed) begin
                  if (|proc_alive) begin
                     latched_ff       <= 1'b1;
                     latched_edge_ff  <= this_edge_ff;
                     latched_procs_ff <= rag_pkg::PROCS_OUT_W'(proc_alive);
                  end
                  state_ff <= DONE;
               end
            end
            DONE: begin
               // Hold the result until the output register is free.
               if (slot_free) begin
                  rsp_edge_number_ff      <= this_edge_ff;
                  rsp_deadlock_ff         <= latched_ff;
                  rsp_deadlock_edge_ff    <= latched_ff ? latched_edge_ff : '0;
                  rsp_deadlocked_procs_ff <= latched_ff ? latched_procs_ff : '0;
                  state_ff                <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_edge_number      = rsp_edge_number_ff;
   assign rsp_deadlock         = rsp_deadlock_ff;
   assign rsp_deadlock_edge    = rsp_deadlock_edge_ff;
   assign rsp_deadlocked_procs = rsp_deadlocked_procs_ff;

endmodule

FILE: hdl/rag_cell.sv
// One process cell: its request row, its assignment column and its alive flag.
module rag_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  rag_pkg::cell_ctl_type     ctl,
   input  logic                      sel,
   input  logic [rag_pkg::NUM_RES-1:0] res_alive,
   input  rag_pkg::cell_chain_type   chain_in,
   output rag_pkg::cell_chain_type   chain_out,
   output logic                      alive
);

   logic [rag_pkg::NUM_RES-1:0] req_row_ff, req_row_in;
   logic [rag_pkg::NUM_RES-1:0] asg_col_ff, asg_col_in;
   logic                        alive_ff, alive_in;
   logic                        alive_next;

   // A process survives a round only while it still waits on a live resource.
   assign alive_next = alive_ff & (|(req_row_ff & res_alive));

   always_comb begin
      req_row_in = ctl.clear ? '0 : req_row_ff;
      asg_col_in = ctl.clear ? '0 : asg_col_ff;
      if (sel && ctl.wr_req) begin
         req_row_in[ctl.res_id] = 1'b1;
      end
      if (sel && ctl.wr_asg) begin
         asg_col_in[ctl.res_id] = 1'b1;
      end
      if (ctl.start) begin
         alive_in = 1'b1;
      end else if (ctl.step) begin
         alive_in = alive_next;
      end else begin
         alive_in = alive_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_row_ff <= '0;
         asg_col_ff <= '0;
         alive_ff   <= 1'b0;
      end else begin
         req_row_ff <= req_row_in;
         asg_col_ff <= asg_col_in;
         alive_ff   <= alive_in;
      end
   end

   // Pass on which resources a live process still holds, and whether this cell dropped.
   assign chain_out.res_any = chain_in.res_any | (alive_ff ? asg_col_ff : '0);
   assign chain_out.changed = chain_in.changed | (alive_ff & ~alive_next);
   assign alive             = alive_ff;

endmodule

FILE: hdl/rag_checker.sv
// Port-level checks for the deadlock detector, bound to the top level.
module rag_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_type,
   input logic [rag_pkg::ID_W-1:0]          req_proc_id,
   input logic [rag_pkg::ID_W-1:0]          req_res_id,
   input logic                              req_first_edge,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [rag_pkg::CNT_W-1:0]         rsp_edge_number,
   input logic                              rsp_deadlock,
   input logic [rag_pkg::CNT_W-1:0]         rsp_deadlock_edge,
   input logic [rag_pkg::PROCS_OUT_W-1:0]   rsp_deadlocked_procs
);

   // A stalled result beat holds its edge number and its process mask.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_edge_number) &&
                                  $stable(rsp_deadlocked_procs))
      else $error("rsp beat changed while stalled");

   // A reported deadlock always names at least one process.
   a_dl_procs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_deadlock |-> rsp_deadlocked_procs != '0)
      else $error("deadlock reported with empty process mask");

   // Without a deadlock, the latched fields read zero.
   a_no_dl_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_deadlock |-> rsp_deadlock_edge == '0 &&
                                     rsp_deadlocked_procs == '0)
      else $error("latched fields nonzero without deadlock");

   // The deadlocking edge never lies after the edge being reported.
   a_dl_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_deadlock |-> rsp_deadlock_edge <= rsp_edge_number)
      else $error("deadlock edge later than current edge");

endmodule

bind rag_deadlock_detector rag_checker u_rag_checker (.*);

FILE: tb/sv/tb.sv
// Self-checking testbench for the allocation-graph deadlock detector.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic {EDGE_REQUEST = 1'b0, EDGE_ASSIGN = 1'b1} edge_kind_type;

   typedef struct {
      edge_kind_type            kind;
      logic [rag_pkg::ID_W-1:0] proc_id;
      logic [rag_pkg::ID_W-1:0] res_id;
      logic                     fresh;
   } rag_edge_type;

   typedef struct {
      logic [rag_pkg::CNT_W-1:0]       edge_number;
      logic                            deadlock;
      logic [rag_pkg::CNT_W-1:0]       deadlock_edge;
      logic [rag_pkg::PROCS_OUT_W-1:0] procs;
   } verdict_type;

   typedef int id_list_type[$];

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_type = EDGE_REQUEST;
   logic [rag_pkg::ID_W-1:0]        req_proc_id = '0;
   logic [rag_pkg::ID_W-1:0]        req_res_id = '0;
   logic                            req_first_edge = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [rag_pkg::CNT_W-1:0]       rsp_edge_number;
   logic                            rsp_deadlock;
   logic [rag_pkg::CNT_W-1:0]       rsp_deadlock_edge;
   logic [rag_pkg::PROCS_OUT_W-1:0] rsp_deadlocked_procs;

   // Mirror of the graph and the deadlock latch
   logic [rag_pkg::NUM_RES-1:0]     waits_for [rag_pkg::NUM_PROCS];
   logic [rag_pkg::NUM_PROCS-1:0]   held_by [rag_pkg::NUM_RES];
   logic [rag_pkg::CNT_W-1:0]       next_edge;
   logic                            locked;
   logic [rag_pkg::CNT_W-1:0]       lock_edge;
   logic [rag_pkg::PROCS_OUT_W-1:0] lock_procs;

   verdict_type verdicts_due[$];
   int          fail_count = 0;
   int          edges_sent = 0;
   bit          steady = 1'b0;   // no idling on either side while set

   rag_deadlock_detector dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_type             (req_type),
      .req_proc_id          (req_proc_id),
      .req_res_id           (req_res_id),
      .req_first_edge       (req_first_edge),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_edge_number      (rsp_edge_number),
      .rsp_deadlock         (rsp_deadlock),
      .rsp_deadlock_edge    (rsp_deadlock_edge),
      .rsp_deadlocked_procs (rsp_deadlocked_procs)
   );

   always #5 clock = ~clock;

   initial begin
      #40_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic void forget_graph();
      for (int i = 0; i < rag_pkg::NUM_PROCS; i++) waits_for[i] = '0;
      for (int i = 0; i < rag_pkg::NUM_RES; i++) held_by[i] = '0;
      next_edge = '0;
      locked = 1'b0;
      lock_edge = '0;
      lock_procs = '0;
   endfunction

   // Peel sinks to a fixed point; whatever process is left is deadlocked.
   function automatic logic [rag_pkg::NUM_PROCS-1:0] unreduced_procs();
      logic [rag_pkg::NUM_PROCS-1:0] procs;
      logic [rag_pkg::NUM_RES-1:0]   res;
      logic                          changed;
      procs = '1;
      res = '1;
      changed = 1'b1;
      while (changed) begin
         changed = 1'b0;
         for (int p = 0; p < rag_pkg::NUM_PROCS; p++) begin
            if (procs[p] && (waits_for[p] & res) == '0) begin
               procs[p] = 1'b0;
               changed = 1'b1;
            end
         end
         for (int r = 0; r < rag_pkg::NUM_RES; r++) begin
            if (res[r] && (held_by[r] & procs) == '0) begin
               res[r] = 1'b0;
               changed = 1'b1;
            end
         end
      end
      return procs;
   endfunction

   function automatic verdict_type apply_edge(rag_edge_type e);
      verdict_type                   v;
      logic [rag_pkg::NUM_PROCS-1:0] left;
      if (e.fresh) forget_graph();
      v.edge_number = next_edge;
      if (next_edge != rag_pkg::CNT_MAX) next_edge = next_edge + 1'b1;
      // a latched deadlock freezes the graph
      if (!locked) begin
         if (e.kind == EDGE_REQUEST) waits_for[e.proc_id][e.res_id] = 1'b1;
         else held_by[e.res_id][e.proc_id] = 1'b1;
         left = unreduced_procs();
         if (left != '0) begin
            locked = 1'b1;
            lock_edge = v.edge_number;
            lock_procs = left[rag_pkg::PROCS_OUT_W-1:0];
         end
      end
      v.deadlock = locked;
      v.deadlock_edge = locked ? lock_edge : '0;
      v.procs = locked ? lock_procs : '0;
      return v;
   endfunction

   function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
      fail_count++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
   endfunction

   function automatic id_list_type shuffled_ids();
      id_list_type ids;
      int          j;
      int          tmp;
      for (int i = 0; i < 32; i++) ids.insert(ids.size(), i);
      for (int i = 31; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = ids[i];
         ids[i] = ids[j];
         ids[j] = tmp;
      end
      return ids;
   endfunction

   // Response side: random stalls, compare each beat with the oldest prediction.
   always @(posedge clock) begin : rsp_check
      verdict_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 38);
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected beat: expected none, actual edge_number %0d",
                        $time, rsp_edge_number);
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_edge_number !== want.edge_number)
                  note_mismatch("edge_number", 32'(want.edge_number), 32'(rsp_edge_number));
               if (rsp_deadlock !== want.deadlock)
                  note_mismatch("deadlock", 32'(want.deadlock), 32'(rsp_deadlock));
               if (rsp_deadlock_edge !== want.deadlock_edge)
                  note_mismatch("deadlock_edge", 32'(want.deadlock_edge),
                                32'(rsp_deadlock_edge));
               if (rsp_deadlocked_procs !== want.procs)
                  note_mismatch("deadlocked_procs", 32'(want.procs),
                                32'(rsp_deadlocked_procs));
            end
         end
      end
   end

   task automatic send_edge(edge_kind_type kind, int proc_id, int res_id, bit fresh);
      rag_edge_type e;
      while (!steady && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      e.kind = kind;
      e.proc_id = proc_id[rag_pkg::ID_W-1:0];
      e.res_id = res_id[rag_pkg::ID_W-1:0];
      e.fresh = fresh;
      req_valid <= 1'b1;
      req_type <= e.kind;
      req_proc_id <= e.proc_id;
      req_res_id <= e.res_id;
      req_first_edge <= e.fresh;
      do @(posedge clock); while (!req_ready);
      verdicts_due.insert(verdicts_due.size(), apply_edge(e));
      edges_sent++;
   endtask

   // Hold the sender until every outstanding result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_acyclic_extremes();
      send_edge(EDGE_REQUEST, 0, 0, 1'b1);
      send_edge(EDGE_ASSIGN, 31, 31, 1'b0);
      send_edge(EDGE_REQUEST, 31, 0, 1'b0);
      send_edge(EDGE_REQUEST, 31, 0, 1'b0);   // duplicate edge
      send_edge(EDGE_ASSIGN, 0, 31, 1'b0);
      send_edge(EDGE_REQUEST, 21, 10, 1'b0);
      send_edge(EDGE_ASSIGN, 10, 21, 1'b0);
      drain();
   endtask

   task automatic test_cycle_with_waiter();
      send_edge(EDGE_REQUEST, 2, 0, 1'b1);
      send_edge(EDGE_REQUEST, 0, 0, 1'b0);
      send_edge(EDGE_ASSIGN, 1, 0, 1'b0);
      send_edge(EDGE_REQUEST, 1, 1, 1'b0);
      send_edge(EDGE_ASSIGN, 0, 1, 1'b0);     // closes the cycle, P2 waits on it
      // edges after the latch are counted but not stored
      send_edge(EDGE_REQUEST, 3, 3, 1'b0);
      send_edge(EDGE_ASSIGN, 3, 3, 1'b0);
      drain();
   endtask

   task automatic test_restart_after_latch();
      send_edge(EDGE_ASSIGN, 31, 31, 1'b1);
      send_edge(EDGE_REQUEST, 31, 31, 1'b0);
      send_edge(EDGE_REQUEST, 31, 31, 1'b1);  // graph cleared, so no deadlock yet
      send_edge(EDGE_ASSIGN, 31, 31, 1'b0);
      drain();
   endtask

   // Latch a deadlock, then stream edges back to back with no idling on either side.
   task automatic test_steady_latched_run();
      send_edge(EDGE_ASSIGN, 5, 5, 1'b1);
      send_edge(EDGE_REQUEST, 5, 5, 1'b0);
      steady = 1'b1;
      for (int i = 0; i < 40; i++)
         send_edge(edge_kind_type'($urandom_range(1)), $urandom_range(31),
                   $urandom_range(31), 1'b0);
      drain();
      steady = 1'b0;
   endtask

   task automatic test_random_graphs();
      int          start;
      int          pick;
      int          pool;
      int          base_p;
      int          base_r;
      int          len;
      id_list_type ps;
      id_list_type rs;
      start = edges_sent;
      while (edges_sent - start < 1400) begin
         pick = $urandom_range(9);
         if (pick < 6) begin
            // dense random edges over a few ids: cycles form often
            pool = $urandom_range(2, 6);
            base_p = $urandom_range(31);
            base_r = $urandom_range(31);
            len = $urandom_range(1, 24);
            for (int n = 0; n < len; n++)
               send_edge(edge_kind_type'($urandom_range(1)),
                         (base_p + $urandom_range(pool - 1)) % 32,
                         (base_r + $urandom_range(pool - 1)) % 32, n == 0);
         end else if (pick < 8) begin
            // long wait chain, closed into a ring half of the time
            ps = shuffled_ids();
            rs = shuffled_ids();
            len = $urandom_range(1, 32);
            for (int n = 0; n < len; n++) begin
               send_edge(EDGE_REQUEST, ps[n], rs[n], n == 0);
               if (n < len - 1) send_edge(EDGE_ASSIGN, ps[n + 1], rs[n], 1'b0);
            end
            if ($urandom_range(1)) send_edge(EDGE_ASSIGN, ps[0], rs[len - 1], 1'b0);
         end else begin
            len = $urandom_range(1, 8);
            for (int n = 0; n < len; n++)
               send_edge(edge_kind_type'($urandom_range(1)), $urandom_range(31),
                         $urandom_range(31), $urandom_range(15) == 0);
         end
         if ($urandom_range(7) == 0) drain();
      end
      drain();
   endtask

   initial begin
      forget_graph();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_acyclic_extremes();
      test_cycle_with_waiter();
      test_restart_after_latch();
      test_steady_latched_run();
      test_random_graphs();
      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/rag_pkg.sv
hdl/rag_cell.sv
hdl/rag_deadlock_detector.sv
hdl/rag_checker.sv
tb/sv/tb.sv
